[rtl/arch_conditional_variance_macros.svh]
// ---------------------------------------------------------------------------
// arch_conditional_variance_macros.svh
// Assertion macros shared by the ARCH variance RTL.
// ---------------------------------------------------------------------------
`ifndef ARCH_CONDITIONAL_VARIANCE_MACROS_SVH
`define ARCH_CONDITIONAL_VARIANCE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ACV_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define ACV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/acv_pkg.sv]
// ---------------------------------------------------------------------------
// acv_pkg
// Types and fixed widths for the ARCH conditional variance engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package acv_pkg;

    // Field widths (fixed by the data formats)
    localparam int RES_W      = 16;  // residual, signed Q4.12
    localparam int HIST_W     = 31;  // stored square, unsigned Q7.24
    localparam int COEF_W     = 16;  // lag coefficient, Q2.14
    localparam int CONST_W    = 32;  // constant term, Q8.24
    localparam int PROD_W     = 32;  // truncated product, Q8.24
    localparam int SUM_W      = 36;  // result, Q12.24
    localparam int FRAC_SHIFT = 14;  // Q9.38 -> Q8.24
    localparam int MAX_LAGS   = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CONST_TERM = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_LAG1  = 3'd1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_RUN
    } acv_state_t;

    // Per-cell control
    typedef struct packed {
        logic shift;    // take the neighbor's square this cycle
        logic zero_in;  // take zero instead (series restart)
    } acv_cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/acv_cell.sv]
// ---------------------------------------------------------------------------
// acv_cell
// One lag tap: holds a stored square, weights it by its coefficient and adds
// the product onto the partial sum handed over from the previous cell.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acv_cell (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire acv_pkg::acv_cell_ctrl_t     ctrl,
    input  wire logic [acv_pkg::HIST_W-1:0]  hist_in,
    input  wire logic [acv_pkg::COEF_W-1:0]  coef,
    input  wire logic [acv_pkg::SUM_W-1:0]   sum_in,
    output logic      [acv_pkg::HIST_W-1:0]  hist_out,
    output logic      [acv_pkg::SUM_W-1:0]   sum_out
);

    localparam int FULL_W = acv_pkg::COEF_W + acv_pkg::HIST_W;

    logic [acv_pkg::HIST_W-1:0] hist_reg;
    logic [acv_pkg::HIST_W-1:0] hist_next;
    logic [acv_pkg::PROD_W-1:0] prod_reg;
    logic [acv_pkg::SUM_W-1:0]  sum_reg;
    logic [FULL_W-1:0]          prod_full;

    // History tap: shift from neighbor, or clear on restart
    always_comb
    begin
        hist_next = hist_reg;
        if (ctrl.shift)
        begin
            hist_next = ctrl.zero_in ? '0 : hist_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
        end
        else
        begin
            hist_reg <= hist_next;
        end
    end

    // Q2.14 * Q7.24, floor to Q8.24 (top bit is always zero)
    assign prod_full = FULL_W'(coef) * FULL_W'(hist_reg);

    // Product and partial sum run every cycle
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full[acv_pkg::FRAC_SHIFT +: acv_pkg::PROD_W];
        sum_reg  <= sum_in + acv_pkg::SUM_W'(prod_reg);
    end

    assign hist_out = hist_reg;
    assign sum_out  = sum_reg;

endmodule

`default_nettype wire

[rtl/arch_conditional_variance.sv]
// ---------------------------------------------------------------------------
// arch_conditional_variance
// ARCH(p) conditional variance: squares each residual into a chain of lag
// cells and returns const_term plus the weighted sum of the stored squares.
// ---------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_ready, residual, restart     | in
//  output  | out_valid, out_ready, next_variance       | out
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
//  One item at a time: the next input transfer waits until the sequencer is back in
//  idle, after the partial-sum wave has walked the cell chain one cell a cycle.
//  The result is registered into the output register once the sum leaves the last cell.
//  A stalled output holds the finished sum in the chain until the output
//  register frees; a new input is taken while a result waits in it.
//  Reset clears history, configuration registers and handshake state; cfg is always ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "arch_conditional_variance_macros.svh"

module arch_conditional_variance #(
    parameter int NUM_LAGS = 7
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // input channel
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic signed [acv_pkg::RES_W-1:0]   residual,
    input  wire logic                               restart,
    // output channel
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic             [acv_pkg::SUM_W-1:0]   next_variance,
    // configuration channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic        [acv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic        [acv_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int DONE_CNT = NUM_LAGS + 1;
    localparam int CNT_W    = $clog2(NUM_LAGS + 2);
    localparam int SQ_W     = 2 * acv_pkg::RES_W;

    acv_pkg::acv_state_t           state_reg, state_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          out_valid_reg, out_valid_next;
    logic [acv_pkg::SUM_W-1:0]     result_reg;
    logic [acv_pkg::RES_W-1:0]     mag_reg;
    logic                          restart_reg;
    logic [acv_pkg::CONST_W-1:0]   const_reg;
    logic [acv_pkg::COEF_W-1:0]    coef_reg [acv_pkg::MAX_LAGS];

    logic                          in_xfer;
    logic                          shift_en;
    logic                          load_out;
    logic [acv_pkg::RES_W-1:0]     mag_next;
    logic [SQ_W-1:0]               sq_full;
    logic [acv_pkg::HIST_W-1:0]    square;

    logic [acv_pkg::HIST_W-1:0]    hist_w [NUM_LAGS];
    logic [acv_pkg::SUM_W-1:0]     sum_w  [NUM_LAGS];

    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            const_reg <= '0;
            for (int i = 0; i < acv_pkg::MAX_LAGS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == acv_pkg::REG_CONST_TERM)
            begin
                const_reg <= cfg_data;
            end
            else
            begin
                coef_reg[cfg_index - acv_pkg::REG_COEF_LAG1] <=
                    cfg_data[acv_pkg::COEF_W-1:0];
            end
        end
    end

    // Residual magnitude (covers the most negative code)
    assign mag_next = residual[acv_pkg::RES_W-1] ? (~residual + 1'b1) : residual;

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mag_reg     <= mag_next;
            restart_reg <= restart;
        end
    end

    // Exact square, at most 2^30
    assign sq_full = SQ_W'(mag_reg) * SQ_W'(mag_reg);
    assign square  = sq_full[acv_pkg::HIST_W-1:0];

    // Sequencer: next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        in_ready       = 1'b0;
        shift_en       = 1'b0;
        load_out       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            acv_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = acv_pkg::ST_SHIFT;
                end
            end
            acv_pkg::ST_SHIFT:
            begin
                shift_en   = 1'b1;
                cnt_next   = '0;
                state_next = acv_pkg::ST_RUN;
            end
            acv_pkg::ST_RUN:
            begin
                if (cnt_reg == CNT_W'(DONE_CNT))
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        load_out       = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = acv_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = acv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= acv_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            result_reg <= sum_w[NUM_LAGS-1];
        end
    end

    assign out_valid     = out_valid_reg;
    assign next_variance = result_reg;

    // Lag cell chain
    for (genvar k = 0; k < NUM_LAGS; k++)
    begin : g_cell
        acv_pkg::acv_cell_ctrl_t   ctrl;
        logic [acv_pkg::HIST_W-1:0] hist_in;
        logic [acv_pkg::SUM_W-1:0]  sum_in;

        if (k == 0)
        begin : g_head
            assign hist_in      = square;
            assign sum_in       = acv_pkg::SUM_W'(const_reg);
            assign ctrl.zero_in = 1'b0;
        end
        else
        begin : g_body
            assign hist_in      = hist_w[k-1];
            assign sum_in       = sum_w[k-1];
            assign ctrl.zero_in = restart_reg;
        end
        assign ctrl.shift = shift_en;

        acv_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .hist_in  (hist_in),
            .coef     (coef_reg[k]),
            .sum_in   (sum_in),
            .hist_out (hist_w[k]),
            .sum_out  (sum_w[k])
        );
    end

    // Checks
    `ACV_ASSERT_NEXT(a_xfer_to_shift, clk, rst_n, in_xfer,
        state_reg == acv_pkg::ST_SHIFT, "input transfer did not start a shift")
    `ACV_ASSERT_NEXT(a_shift_to_run, clk, rst_n, state_reg == acv_pkg::ST_SHIFT,
        (state_reg == acv_pkg::ST_RUN) && (cnt_reg == '0), "shift not followed by run")
    `ACV_ASSERT_NEXT(a_load_sets_valid, clk, rst_n, load_out,
        out_valid_reg && (state_reg == acv_pkg::ST_IDLE), "result load lost")
    `ACV_ASSERT_IMPLY(a_load_when_free, clk, rst_n, load_out,
        !out_valid_reg || out_ready, "result overwrote a pending output")

endmodule

`default_nettype wire

[test/arch_conditional_variance_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// arch_conditional_variance_checker
// Watches the config, input and output channels of the ARCH variance block.
// Keeps its own copy of the registers and of the squared-residual history,
// predicts next_variance for every input transfer and compares each output
// transfer against the oldest prediction still waiting.
// ---------------------------------------------------------------------------
module arch_conditional_variance_checker #(
    parameter int NUM_LAGS = 7
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_ready,
    input  logic signed [acv_pkg::RES_W-1:0]       residual,
    input  logic                                   restart,
    input  logic                                   out_valid,
    input  logic                                   out_ready,
    input  logic        [acv_pkg::SUM_W-1:0]       next_variance,
    input  logic                                   cfg_valid,
    input  logic                                   cfg_ready,
    input  logic        [acv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic        [acv_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                     mismatch_count,
    output int                                     outstanding
);
    import acv_pkg::*;

    localparam int LAGS = (NUM_LAGS < 1) ? 1 : ((NUM_LAGS > MAX_LAGS) ? MAX_LAGS : NUM_LAGS);

    // shadow registers and history
    logic [CONST_W-1:0] const_term_q;
    logic [COEF_W-1:0]  coef_q      [MAX_LAGS];
    logic [HIST_W-1:0]  square_hist [MAX_LAGS];

    // predicted variances, oldest first
    logic [SUM_W-1:0]   variance_q  [$];
    int                 results_seen;

    initial mismatch_count = 0;
    initial outstanding    = 0;

    task automatic flag_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Square the residual into the history (cleared first on a new series), then form the weighted sum
    function automatic logic [SUM_W-1:0] next_date_variance(
        input logic signed [RES_W-1:0] r,
        input logic                    new_series
    );
        logic [RES_W:0]     magnitude;
        logic [2*RES_W+1:0] square;
        logic [47:0]        product;
        logic [SUM_W-1:0]   acc;
        magnitude = r[RES_W-1] ? ({1'b1, {RES_W{1'b0}}} - {1'b0, r}) : {1'b0, r};
        square    = magnitude * magnitude;
        if (new_series)
            for (int k = 0; k < MAX_LAGS; k++)
                square_hist[k] = '0;
        for (int k = LAGS - 1; k > 0; k--)
            square_hist[k] = square_hist[k-1];
        square_hist[0] = square[HIST_W-1:0];
        acc = SUM_W'(const_term_q);
        for (int k = 0; k < LAGS; k++)
        begin
            product = 48'(coef_q[k]) * 48'(square_hist[k]);
            acc     = acc + SUM_W'(product >> FRAC_SHIFT);
        end
        return acc;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        logic [SUM_W-1:0] want;
        if (!rst_n)
        begin
            const_term_q = '0;
            for (int k = 0; k < MAX_LAGS; k++)
            begin
                coef_q[k]      = '0;
                square_hist[k] = '0;
            end
            variance_q.delete();
            results_seen = 0;
            outstanding <= 0;
        end
        else
        begin
            // register write
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_CONST_TERM)
                    const_term_q = cfg_data[CONST_W-1:0];
                else
                    coef_q[cfg_index - REG_COEF_LAG1] = cfg_data[COEF_W-1:0];
            end
            // result transfer
            if (out_valid && out_ready)
            begin
                if (variance_q.size() == 0)
                    flag_mismatch($sformatf("result %0d (0x%09h) with nothing expected",
                                            results_seen, next_variance));
                else
                begin
                    want = variance_q.pop_front();
                    if (next_variance !== want)
                        flag_mismatch($sformatf("result %0d next_variance 0x%09h, expected 0x%09h",
                                                results_seen, next_variance, want));
                end
                results_seen++;
            end
            // input transfer
            if (in_valid && in_ready)
                variance_q.push_back(next_date_variance(residual, restart));
            outstanding <= variance_q.size();
        end
    end

endmodule

[test/arch_conditional_variance_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// arch_conditional_variance_tb
// Stimulus and verdict for the ARCH variance block. Loads several register
// settings (all zero, all ones, small, random), sends directed residuals and
// then random series with restarts, with bursty input and a stalling output.
// The checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module arch_conditional_variance_tb;
    import acv_pkg::*;

    localparam int NUM_LAGS        = 7;
    localparam int CLK_HALF        = 6;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int RANDOM_PHASES   = 6;
    localparam int LONG_HOLD       = 400;
    localparam int SETTLE_CYCLES   = NUM_LAGS + 8;

    typedef enum int {SET_ZERO, SET_FULL, SET_SMALL, SET_RANDOM} setting_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic signed [RES_W-1:0] residual = '0;
    logic                   restart = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [SUM_W-1:0]       next_variance;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int                     mismatch_count;
    int                     outstanding;
    int                     hold_requests = 0;
    int                     burst_left = 0;
    int                     cycle_count = 0;
    logic [CFG_DATA_W-1:0]  reg_words [MAX_LAGS+1];

    arch_conditional_variance #(.NUM_LAGS(NUM_LAGS)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .residual     (residual),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .next_variance(next_variance),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    arch_conditional_variance_checker #(.NUM_LAGS(NUM_LAGS)) chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .residual      (residual),
        .restart       (restart),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .next_variance (next_variance),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatch_count(mismatch_count),
        .outstanding   (outstanding)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Output side: stretches of differing stall patterns, plus long hold-offs on request
    initial
    begin : receiver
        int holds_served;
        int stretch;
        int mode;
        holds_served = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            stretch = $urandom_range(8, 64);
            mode    = $urandom_range(0, 3);
            for (int i = 0; i < stretch; i++)
            begin
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= (i % 4) != 3;
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // one input transfer, opening a new burst after a random gap when due
    task automatic send_item(input logic [RES_W-1:0] r, input logic new_series);
        int gap;
        if (burst_left == 0)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                3:       gap = $urandom_range(13, 40);
                default: gap = $urandom_range(1, 12);
            endcase
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        residual <= r;
        restart  <= new_series;
        do @(posedge clk); while (!in_ready);
        burst_left--;
    endtask

    // stop sending and wait until every predicted result has been taken
    task automatic drain_results();
        in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // write all registers from reg_words, const term first
    task automatic load_registers();
        for (int i = 0; i <= MAX_LAGS; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= (i == 0) ? REG_CONST_TERM : REG_COEF_LAG1 + CFG_IDX_W'(i - 1);
            cfg_data  <= reg_words[i];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic pick_setting(input setting_t s);
        for (int i = 0; i <= MAX_LAGS; i++)
        begin
            case (s)
                SET_ZERO:  reg_words[i] = '0;
                SET_FULL:  reg_words[i] = '1;
                SET_SMALL: reg_words[i] = (i == 0) ? 32'($urandom_range(0, 1 << 24))
                                          : {16'($urandom), 16'($urandom_range(0, 255))};
                default:   reg_words[i] = $urandom;
            endcase
        end
        load_registers();
    endtask

    function automatic logic [RES_W-1:0] random_residual();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return RES_W'($signed($urandom_range(0, 32)) - 16);
            default: return RES_W'($urandom);
        endcase
    endfunction

    initial
    begin : stimulus
        int sent;
        int series_len;
        logic new_series;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: distinct lag weights so a wrong lag shows up
        reg_words[0] = 32'h0100_0000;
        for (int i = 1; i <= MAX_LAGS; i++)
            reg_words[i] = 32'h4000 >> (i - 1);
        load_registers();
        send_item(16'h1000, 1'b1);
        send_item(16'h0000, 1'b0);
        send_item(16'h7FFF, 1'b0);
        send_item(16'h8000, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'h0001, 1'b0);
        send_item(16'hC000, 1'b0);
        send_item(16'h2000, 1'b0);
        send_item(16'h1800, 1'b0);
        // restarts mid-series: only const plus lag one survive
        send_item(16'h8000, 1'b1);
        send_item(16'h0000, 1'b1);
        send_item(16'h7FFF, 1'b0);
        send_item(16'h0100, 1'b1);
        drain_results();

        // Directed: every register at its maximum, history full of the largest square
        pick_setting(SET_FULL);
        send_item(16'h8000, 1'b1);
        for (int i = 0; i < NUM_LAGS; i++)
            send_item(16'h8000, 1'b0);
        send_item(16'h7FFF, 1'b0);
        drain_results();

        // Random series under several settings
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                1:       pick_setting(SET_FULL);
                2:       pick_setting(SET_SMALL);
                3:       pick_setting(SET_ZERO);
                default: pick_setting(SET_RANDOM);
            endcase
            if (p == 1 || p == 4)
                hold_requests <= hold_requests + 1;
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                series_len = $urandom_range(1, 30);
                for (int j = 0; j < series_len && sent < ITEMS_PER_PHASE; j++)
                begin
                    if (j == 0)
                        new_series = ($urandom_range(0, 9) != 0);
                    else
                        new_series = ($urandom_range(0, 49) == 0);
                    send_item(random_residual(), new_series);
                    sent++;
                    if ($urandom_range(0, 149) == 0)
                        drain_results();
                end
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
